>>> design/ipid_pkg.sv
`default_nettype none

package ipid_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned REG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LAW_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAW    = 3'd0,
    REG_P_GAIN = 3'd1,
    REG_I_GAIN = 3'd2,
    REG_D_GAIN = 3'd3,
    REG_UPPER  = 3'd4,
    REG_LOWER  = 3'd5
  } reg_idx_e;

  // Law codes; the two codes above TYPE_C hold the output.
  localparam logic [LAW_W-1:0] LAW_P      = 3'd0;
  localparam logic [LAW_W-1:0] LAW_PI     = 3'd1;
  localparam logic [LAW_W-1:0] LAW_PID    = 3'd2;
  localparam logic [LAW_W-1:0] LAW_TYPE_A = 3'd3;
  localparam logic [LAW_W-1:0] LAW_TYPE_B = 3'd4;
  localparam logic [LAW_W-1:0] LAW_TYPE_C = 3'd5;

  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_PRESET  = 1'b1;

  localparam logic [LAW_W-1:0]        LAW_RESET   = LAW_PID;
  localparam logic signed [REG_W-1:0] UPPER_RESET = 32'sh7FFF_FFFF;
  localparam logic signed [REG_W-1:0] LOWER_RESET = 32'sh8000_0000;

  typedef struct packed {
    logic [LAW_W-1:0]        law;
    logic signed [REG_W-1:0] p_gain;
    logic signed [REG_W-1:0] i_gain;
    logic signed [REG_W-1:0] d_gain;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic preset;
    logic upper_wins;
  } stage_ctl_t;

endpackage

`default_nettype wire

>>> design/ipid_cfg.sv
`default_nettype none

module ipid_cfg #(
  parameter int unsigned DATA_WIDTH = ipid_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     cfg_we_i,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  wire logic [ipid_pkg::REG_W-1:0]               cfg_data_i,
  output ipid_pkg::cfg_t                                cfg_o,
  output logic signed [DATA_WIDTH-1:0]                  upper_o,
  output logic signed [DATA_WIDTH-1:0]                  lower_o
);
  import ipid_pkg::*;

  localparam int unsigned W = DATA_WIDTH + 34;
  localparam logic signed [W-1:0] VMAX_W = (W'(1) <<< (DATA_WIDTH - 1)) - W'(1);
  localparam logic signed [W-1:0] VMIN_W = -VMAX_W - W'(1);

  function automatic logic signed [DATA_WIDTH-1:0] sat_in(input logic signed [REG_W-1:0] v);
    logic signed [W-1:0] w;
    w = W'(v);
    if (w > VMAX_W) return VMAX_W[DATA_WIDTH-1:0];
    if (w < VMIN_W) return VMIN_W[DATA_WIDTH-1:0];
    return w[DATA_WIDTH-1:0];
  endfunction

  localparam logic signed [DATA_WIDTH-1:0] UPPER_RST = sat_in(UPPER_RESET);
  localparam logic signed [DATA_WIDTH-1:0] LOWER_RST = sat_in(LOWER_RESET);

  cfg_t                          cfg_q;
  logic signed [DATA_WIDTH-1:0]  upper_q;
  logic signed [DATA_WIDTH-1:0]  lower_q;

  // Limits are stored already saturated to the data width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.law    <= LAW_RESET;
      cfg_q.p_gain <= '0;
      cfg_q.i_gain <= '0;
      cfg_q.d_gain <= '0;
      upper_q      <= UPPER_RST;
      lower_q      <= LOWER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LAW:    cfg_q.law    <= cfg_data_i[LAW_W-1:0];
        REG_P_GAIN: cfg_q.p_gain <= cfg_data_i;
        REG_I_GAIN: cfg_q.i_gain <= cfg_data_i;
        REG_D_GAIN: cfg_q.d_gain <= cfg_data_i;
        REG_UPPER:  upper_q      <= sat_in(cfg_data_i);
        REG_LOWER:  lower_q      <= sat_in(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cfg_o   = cfg_q;
  assign upper_o = upper_q;
  assign lower_o = lower_q;

endmodule

`default_nettype wire

>>> design/ipid_front.sv
`default_nettype none

module ipid_front #(
  parameter int unsigned DATA_WIDTH = ipid_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = ipid_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ipid_pkg::cfg_t                      cfg_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                cmd_i,
  input  wire logic signed [ipid_pkg::REG_W-1:0]   process_value_i,
  input  wire logic signed [ipid_pkg::REG_W-1:0]   target_i,
  input  wire logic signed [ipid_pkg::REG_W-1:0]   preset_value_i,
  input  wire logic                                ready_i,
  output ipid_pkg::stage_ctl_t                     ctl_o,
  output logic signed [DATA_WIDTH:0]               pt_o,
  output logic signed [DATA_WIDTH:0]               it_o,
  output logic signed [DATA_WIDTH:0]               dt_o,
  output logic signed [DATA_WIDTH-1:0]             preset_o
);
  import ipid_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned W  = DW + 34;
  localparam logic signed [W-1:0] VMAX_W = (W'(1) <<< (DW - 1)) - W'(1);
  localparam logic signed [W-1:0] VMIN_W = -VMAX_W - W'(1);

  function automatic logic signed [DW-1:0] sat_w(input logic signed [W-1:0] v);
    if (v > VMAX_W) return VMAX_W[DW-1:0];
    if (v < VMIN_W) return VMIN_W[DW-1:0];
    return v[DW-1:0];
  endfunction

  // Exact product, floor shift, saturate.
  function automatic logic signed [DW-1:0] mulq(input logic signed [REG_W-1:0] g,
                                                input logic signed [DW-1:0] x);
    logic signed [W-1:0] prod;
    prod = W'(g) * W'(x);
    return sat_w(prod >>> FRAC_BITS);
  endfunction

  function automatic logic signed [DW:0] term(input logic signed [DW-1:0] m,
                                              input logic en, input logic neg);
    logic signed [DW:0] e;
    e = (DW + 1)'(m);
    if (!en) return '0;
    return neg ? -e : e;
  endfunction

  // Input register
  logic                 s1_valid_q;
  logic                 s1_cmd_q;
  logic signed [DW-1:0] s1_pv_q, s1_sp_q, s1_preset_q;

  // History
  logic signed [DW-1:0] prev_pv_q, prev_prev_pv_q, prev_err_q, prev_prev_err_q;

  // Product register
  stage_ctl_t           s2_ctl_q;
  logic signed [DW:0]   s2_pt_q, s2_it_q, s2_dt_q;
  logic signed [DW-1:0] s2_preset_q;

  logic ready2, s1_adv;
  logic signed [W-1:0]  pv_w, sp_w;
  logic signed [DW-1:0] err, dpv, d2pv, derr, d2err, xp, xd, mp, mi, md;
  logic law_ok, use_err_p, neg_p, en_i, en_d, use_err_d, upper_wins;

  assign ready2     = !s2_ctl_q.valid || ready_i;
  assign s1_adv     = s1_valid_q && ready2;
  assign in_ready_o = !s1_valid_q || ready2;

  always_comb begin
    pv_w  = W'(s1_pv_q);
    sp_w  = W'(s1_sp_q);
    err   = sat_w(sp_w - pv_w);
    dpv   = sat_w(pv_w - W'(prev_pv_q));
    d2pv  = sat_w(pv_w - (W'(prev_pv_q) <<< 1) + W'(prev_prev_pv_q));
    derr  = sat_w(W'(err) - W'(prev_err_q));
    d2err = sat_w(W'(err) - (W'(prev_err_q) <<< 1) + W'(prev_prev_err_q));

    law_ok     = cfg_i.law <= LAW_TYPE_C;
    use_err_p  = (cfg_i.law == LAW_TYPE_A) || (cfg_i.law == LAW_TYPE_B);
    neg_p      = !use_err_p;
    en_i       = law_ok && (cfg_i.law != LAW_P);
    en_d       = law_ok && (cfg_i.law != LAW_P) && (cfg_i.law != LAW_PI);
    use_err_d  = cfg_i.law == LAW_TYPE_A;
    upper_wins = cfg_i.law > LAW_PID;

    xp = use_err_p ? derr : dpv;
    xd = use_err_d ? d2err : d2pv;
    mp = mulq(cfg_i.p_gain, xp);
    mi = mulq(cfg_i.i_gain, err);
    md = mulq(cfg_i.d_gain, xd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q    <= cmd_i;
      s1_pv_q     <= sat_w(W'(process_value_i));
      s1_sp_q     <= sat_w(W'(target_i));
      s1_preset_q <= sat_w(W'(preset_value_i));
    end
  end

  // As a request leaves: preset clears history, else shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pv_q       <= '0;
      prev_prev_pv_q  <= '0;
      prev_err_q      <= '0;
      prev_prev_err_q <= '0;
    end else if (s1_adv) begin
      if (s1_cmd_q == CMD_PRESET) begin
        prev_pv_q       <= '0;
        prev_prev_pv_q  <= '0;
        prev_err_q      <= '0;
        prev_prev_err_q <= '0;
      end else begin
        prev_prev_pv_q <= prev_pv_q;
        prev_pv_q      <= s1_pv_q;
        if (upper_wins) begin
          prev_prev_err_q <= prev_err_q;
          prev_err_q      <= err;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      if (ready2) begin
        s2_ctl_q.valid <= s1_valid_q;
      end
      if (s1_adv) begin
        s2_ctl_q.preset     <= s1_cmd_q == CMD_PRESET;
        s2_ctl_q.upper_wins <= upper_wins;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_pt_q     <= term(mp, law_ok, neg_p);
      s2_it_q     <= term(mi, en_i, 1'b0);
      s2_dt_q     <= term(md, en_d, !use_err_d);
      s2_preset_q <= s1_preset_q;
    end
  end

  assign ctl_o    = s2_ctl_q;
  assign pt_o     = s2_pt_q;
  assign it_o     = s2_it_q;
  assign dt_o     = s2_dt_q;
  assign preset_o = s2_preset_q;

endmodule

`default_nettype wire

>>> design/ipid_back.sv
`default_nettype none

module ipid_back #(
  parameter int unsigned DATA_WIDTH = ipid_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic signed [DATA_WIDTH-1:0]       upper_i,
  input  wire logic signed [DATA_WIDTH-1:0]       lower_i,
  input  wire ipid_pkg::stage_ctl_t               ctl_i,
  input  wire logic signed [DATA_WIDTH:0]         pt_i,
  input  wire logic signed [DATA_WIDTH:0]         it_i,
  input  wire logic signed [DATA_WIDTH:0]         dt_i,
  input  wire logic signed [DATA_WIDTH-1:0]       preset_i,
  output logic                                    ready_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [ipid_pkg::REG_W-1:0]       drive_o
);
  import ipid_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned W  = DW + 3;
  localparam logic signed [W-1:0] VMAX_W = (W'(1) <<< (DW - 1)) - W'(1);
  localparam logic signed [W-1:0] VMIN_W = -VMAX_W - W'(1);

  function automatic logic signed [DW-1:0] sat_w(input logic signed [W-1:0] v);
    if (v > VMAX_W) return VMAX_W[DW-1:0];
    if (v < VMIN_W) return VMIN_W[DW-1:0];
    return v[DW-1:0];
  endfunction

  logic signed [DW-1:0] last_q, last_d, out_q, result, y, y_lw, y_uw, pre_lw, t;
  logic                 valid_q;
  logic signed [DW+REG_W-1:0] drive_ext;

  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    y = sat_w(W'(last_q) + W'(pt_i) + W'(it_i) + W'(dt_i));

    // Lower limit wins when the limits cross.
    t    = (y > upper_i) ? upper_i : y;
    y_lw = (t < lower_i) ? lower_i : t;
    t    = (preset_i > upper_i) ? upper_i : preset_i;
    pre_lw = (t < lower_i) ? lower_i : t;

    // Upper limit is tested first here; it wins when y exceeds it.
    priority if (y > upper_i) begin
      y_uw = upper_i;
    end else if (y < lower_i) begin
      y_uw = lower_i;
    end else begin
      y_uw = y;
    end

    priority if (ctl_i.preset) begin
      result = pre_lw;
      last_d = pre_lw;
    end else if (ctl_i.upper_wins) begin
      result = y_uw;
      last_d = y;
    end else begin
      result = y_lw;
      last_d = y_lw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= '0;
    end else if (ready_o) begin
      valid_q <= ctl_i.valid;
      if (ctl_i.valid) begin
        last_q <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      out_q <= result;
    end
  end

  assign drive_ext   = (DW + REG_W)'(out_q);
  assign drive_o     = drive_ext[REG_W-1:0];
  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

>>> design/incremental_pid_controller_top.sv
`default_nettype none

// Channel   Direction  Handshake                    Payload
// config    in         cfg_we_i (no wait)           cfg_idx_i, cfg_data_i
// request   in         in_valid_i / in_ready_o      cmd_i, process_value_i, target_i,
//                                                   preset_value_i
// result    out        out_valid_o / out_ready_i    drive_o
//
// One request per cycle sustained while results are taken; each request passes through
// the input register, then the product register, then the output register.
// The rate is set by the last-output loop: sum of terms, saturate and clamp are combinational.
// Reset restores the register defaults and clears output valid, last output and history.
// A stalled result holds the output register; the earlier stages keep filling behind it.

module incremental_pid_controller_top #(
  parameter int unsigned DATA_WIDTH = ipid_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = ipid_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ipid_pkg::REG_W-1:0]          cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                cmd_i,
  input  wire logic signed [ipid_pkg::REG_W-1:0]   process_value_i,
  input  wire logic signed [ipid_pkg::REG_W-1:0]   target_i,
  input  wire logic signed [ipid_pkg::REG_W-1:0]   preset_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [ipid_pkg::REG_W-1:0]        drive_o
);
  import ipid_pkg::*;

  cfg_t                          cfg;
  stage_ctl_t                    fb_ctl;
  logic signed [DATA_WIDTH-1:0]  upper, lower, fb_preset;
  logic signed [DATA_WIDTH:0]    fb_pt, fb_it, fb_dt;
  logic                          back_ready;

  ipid_cfg #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg),
    .upper_o   (upper),
    .lower_o   (lower)
  );

  ipid_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .process_value_i(process_value_i),
    .target_i       (target_i),
    .preset_value_i (preset_value_i),
    .ready_i        (back_ready),
    .ctl_o          (fb_ctl),
    .pt_o           (fb_pt),
    .it_o           (fb_it),
    .dt_o           (fb_dt),
    .preset_o       (fb_preset)
  );

  ipid_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upper_i    (upper),
    .lower_i    (lower),
    .ctl_i      (fb_ctl),
    .pt_i       (fb_pt),
    .it_i       (fb_it),
    .dt_i       (fb_dt),
    .preset_i   (fb_preset),
    .ready_o    (back_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_o    (drive_o)
  );

`ifndef SYNTHESIS
  // An empty product stage never blocks new requests.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fb_ctl.valid |-> in_ready_o)
    else $error("request refused with empty product stage");

  // A blocked product stage holds its request.
  a_products_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_ctl.valid && !back_ready |=> fb_ctl.valid && $stable(fb_ctl) && $stable(fb_pt))
    else $error("product stage lost a request under stall");

  // A request taken by the back stage becomes a result next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_ctl.valid && back_ready |=> out_valid_o)
    else $error("result missing after back stage took a request");
`endif

endmodule

`default_nettype wire
